[design/crw_pkg.sv]
// Shared types and codes for the class A receive window sequencer.
// No dependencies; used by class_a_receive_window_mac.
package crw_pkg;

  // Sequencer states, encoded as they appear on the mac_state output.
  typedef enum logic [2:0] {
    StIdle    = 3'd0,
    StTx      = 3'd1,
    StDelay1  = 3'd2,
    StListen1 = 3'd3,
    StRx1     = 3'd4,
    StDelay2  = 3'd5,
    StListen2 = 3'd6,
    StRx2     = 3'd7
  } mac_state_e;

  // Event codes carried in the command field.
  localparam logic [2:0] CmdTick     = 3'd0;
  localparam logic [2:0] CmdSend     = 3'd1;
  localparam logic [2:0] CmdTxDone   = 3'd2;
  localparam logic [2:0] CmdRxChange = 3'd3;
  localparam logic [2:0] CmdFrame    = 3'd4;
  localparam logic [2:0] CmdDrop     = 3'd5;

  // Radio modes.
  localparam logic [1:0] RadioSleep = 2'd0;
  localparam logic [1:0] RadioTx    = 2'd1;
  localparam logic [1:0] RadioRx    = 2'd2;

  // Register indexes on the configuration port (byte address is 8 times this).
  localparam logic [2:0] RegDelayOne  = 3'd0;
  localparam logic [2:0] RegListenOne = 3'd1;
  localparam logic [2:0] RegDelayTwo  = 3'd2;
  localparam logic [2:0] RegListenTwo = 3'd3;
  localparam logic [2:0] RegOwnAddr   = 3'd4;

  localparam int unsigned TickW = 18;
  localparam logic [TickW-1:0] TickMax = {TickW{1'b1}};
  localparam int unsigned AddrW = 48;

endpackage

[design/class_a_receive_window_mac.sv]
// Top level of the class A receive window sequencer: event channel, result
// channel and configuration port. Depends on crw_pkg.
//
// Usage:
// Each input item is one event (tick, send request, transmit finished,
// reception change, frame received, frame dropped). The block answers every
// event with exactly one result item: the state and radio mode after the
// event, the start/deliver/discard/error flags and the sent and received
// frame counters.
// The event is evaluated in the cycle it is accepted, and its result is
// presented from the next cycle on. A new event is accepted in every cycle
// in which the result register is empty or its item is being taken, which
// gives a sustained rate of one item per cycle. The limit is the single
// result register: the state update and the deadline compares are combinational.
// If the receiver stalls, the result holds and in_ready_o drops until it is
// taken; no event is lost or reordered.
// Reset puts the block in idle with the radio asleep, the windows disarmed,
// the counters at zero and all window lengths at one tick. The configuration
// port uses 64-bit data with register i at byte address 8*i; pready is always
// high and writes should happen only while the block is idle.
module class_a_receive_window_mac (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Event channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic        receiving_i,
  input  logic [47:0] dest_address_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  mac_state_o,
  output logic [1:0]  radio_mode_o,
  output logic        start_send_o,
  output logic        deliver_frame_o,
  output logic        discard_frame_o,
  output logic        request_error_o,
  output logic [31:0] sent_count_o,
  output logic [31:0] received_count_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [15:0] delay_one_q, listen_one_q, delay_two_q, listen_two_q;
  logic [crw_pkg::AddrW-1:0] own_addr_q;
  logic [2:0] reg_idx;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[5:3];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_one_q  <= 16'd1;
      listen_one_q <= 16'd1;
      delay_two_q  <= 16'd1;
      listen_two_q <= 16'd1;
      own_addr_q   <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        crw_pkg::RegDelayOne:  delay_one_q  <= pwdata[15:0];
        crw_pkg::RegListenOne: listen_one_q <= pwdata[15:0];
        crw_pkg::RegDelayTwo:  delay_two_q  <= pwdata[15:0];
        crw_pkg::RegListenTwo: listen_two_q <= pwdata[15:0];
        crw_pkg::RegOwnAddr:   own_addr_q   <= pwdata[crw_pkg::AddrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      crw_pkg::RegDelayOne:  prdata = {48'd0, delay_one_q};
      crw_pkg::RegListenOne: prdata = {48'd0, listen_one_q};
      crw_pkg::RegDelayTwo:  prdata = {48'd0, delay_two_q};
      crw_pkg::RegListenTwo: prdata = {48'd0, listen_two_q};
      crw_pkg::RegOwnAddr:   prdata = {16'd0, own_addr_q};
      default:               prdata = '0;
    endcase
  end

  // Cumulative deadlines, measured in ticks from the end of the transmission.
  // Four 16-bit terms always fit in the 18-bit tick range.
  logic [crw_pkg::TickW-1:0] deadline [4];

  always_comb begin
    deadline[0] = {2'b00, delay_one_q};
    deadline[1] = deadline[0] + {2'b00, listen_one_q};
    deadline[2] = deadline[1] + {2'b00, delay_two_q};
    deadline[3] = deadline[2] + {2'b00, listen_two_q};
  end

  // Sequencer state. The state, radio mode and counters are reported as they
  // stand after the last event, so they drive the result ports directly.
  crw_pkg::mac_state_e state_q, state_d;
  logic [1:0]  radio_q, radio_d;
  logic        armed_q, armed_d;
  logic        was_rx_q, was_rx_d;
  logic [crw_pkg::TickW-1:0] ticks_q, ticks_d;
  logic [31:0] sent_q, sent_d, recv_q, recv_d;
  logic        start_q, start_d, deliver_q, deliver_d;
  logic        discard_q, discard_d, req_err_q, req_err_d;
  logic        out_valid_q;
  logic        accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  logic [3:0] fired, passed;
  logic       run_fsm;
  logic       medium_on, for_us;
  crw_pkg::mac_state_e next_st;
  logic       do_enter;

  always_comb begin
    state_d   = state_q;
    radio_d   = radio_q;
    armed_d   = armed_q;
    was_rx_d  = was_rx_q;
    ticks_d   = ticks_q;
    sent_d    = sent_q;
    recv_d    = recv_q;
    start_d   = 1'b0;
    deliver_d = 1'b0;
    discard_d = 1'b0;
    req_err_d = 1'b0;
    run_fsm   = 1'b0;
    do_enter  = 1'b0;
    next_st   = state_q;
    fired     = '0;

    // A tick advances the counter only while the windows are armed.
    if (command_i == crw_pkg::CmdTick && armed_q && ticks_q != crw_pkg::TickMax) begin
      ticks_d = ticks_q + crw_pkg::TickW'(1);
    end

    for (int k = 0; k < 4; k++) begin
      if (command_i == crw_pkg::CmdTick && armed_q && ticks_d == deadline[k]) begin
        fired[k] = 1'b1;
      end
    end

    case (command_i)
      crw_pkg::CmdTick: run_fsm = |fired;
      crw_pkg::CmdSend: begin
        if (state_q == crw_pkg::StIdle) begin
          run_fsm = 1'b1;
        end else begin
          req_err_d = 1'b1;
        end
      end
      crw_pkg::CmdTxDone: run_fsm = 1'b1;
      crw_pkg::CmdRxChange: begin
        if (was_rx_q) begin
          radio_d = crw_pkg::RadioSleep;
        end
        was_rx_d = receiving_i;
        run_fsm  = 1'b1;
      end
      crw_pkg::CmdFrame: begin
        if (state_q == crw_pkg::StRx1 || state_q == crw_pkg::StRx2) begin
          run_fsm = 1'b1;
        end else begin
          discard_d = 1'b1;
        end
      end
      crw_pkg::CmdDrop: begin
        radio_d = crw_pkg::RadioSleep;
        run_fsm = 1'b1;
      end
      default: ;
    endcase

    // A deadline counts as passed once it is no longer pending.
    for (int k = 0; k < 4; k++) begin
      passed[k] = fired[k] || !(armed_q && ticks_d < deadline[k]);
    end

    medium_on = (command_i == crw_pkg::CmdRxChange) && receiving_i;
    for_us    = dest_address_i == own_addr_q;

    if (run_fsm) begin
      unique case (state_q)
        crw_pkg::StIdle: begin
          if (command_i == crw_pkg::CmdSend) begin
            do_enter = 1'b1;
            next_st  = crw_pkg::StTx;
          end
        end
        crw_pkg::StTx: begin
          if (command_i == crw_pkg::CmdTxDone) begin
            armed_d  = 1'b1;
            ticks_d  = '0;
            sent_d   = sent_q + 32'd1;
            do_enter = 1'b1;
            next_st  = crw_pkg::StDelay1;
          end
        end
        crw_pkg::StDelay1: begin
          if (passed[0]) begin
            do_enter = 1'b1;
            next_st  = crw_pkg::StListen1;
          end
        end
        crw_pkg::StListen1: begin
          if (passed[1]) begin
            do_enter = 1'b1;
            next_st  = crw_pkg::StDelay2;
          end else if (medium_on) begin
            do_enter = 1'b1;
            next_st  = crw_pkg::StRx1;
          end
        end
        crw_pkg::StDelay2: begin
          if (passed[2]) begin
            do_enter = 1'b1;
            next_st  = crw_pkg::StListen2;
          end
        end
        crw_pkg::StListen2: begin
          if (passed[3]) begin
            do_enter = 1'b1;
            next_st  = crw_pkg::StIdle;
          end else if (medium_on) begin
            do_enter = 1'b1;
            next_st  = crw_pkg::StRx2;
          end
        end
        crw_pkg::StRx1, crw_pkg::StRx2: begin
          if (command_i == crw_pkg::CmdFrame && for_us) begin
            deliver_d = 1'b1;
            recv_d    = recv_q + 32'd1;
            do_enter  = 1'b1;
            next_st   = crw_pkg::StIdle;
          end else if (command_i == crw_pkg::CmdFrame || command_i == crw_pkg::CmdDrop) begin
            discard_d = (command_i == crw_pkg::CmdFrame);
            do_enter  = 1'b1;
            next_st   = (state_q == crw_pkg::StRx1) ? crw_pkg::StListen1
                                                    : crw_pkg::StListen2;
          end
        end
        default: ;
      endcase
    end

    // Entering a state sets the radio; the receive states leave it alone.
    if (do_enter) begin
      state_d = next_st;
      unique case (next_st)
        crw_pkg::StIdle: begin
          radio_d = crw_pkg::RadioSleep;
          armed_d = 1'b0;
        end
        crw_pkg::StTx: begin
          radio_d = crw_pkg::RadioTx;
          start_d = 1'b1;
        end
        crw_pkg::StDelay1, crw_pkg::StDelay2: radio_d = crw_pkg::RadioSleep;
        crw_pkg::StListen1, crw_pkg::StListen2: radio_d = crw_pkg::RadioRx;
        default: ;
      endcase
    end

    // The end of a transmission always puts the radio to sleep.
    if (command_i == crw_pkg::CmdTxDone) begin
      radio_d = crw_pkg::RadioSleep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crw_pkg::StIdle;
      radio_q     <= crw_pkg::RadioSleep;
      armed_q     <= 1'b0;
      was_rx_q    <= 1'b0;
      ticks_q     <= '0;
      sent_q      <= '0;
      recv_q      <= '0;
      start_q     <= 1'b0;
      deliver_q   <= 1'b0;
      discard_q   <= 1'b0;
      req_err_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q   <= state_d;
        radio_q   <= radio_d;
        armed_q   <= armed_d;
        was_rx_q  <= was_rx_d;
        ticks_q   <= ticks_d;
        sent_q    <= sent_d;
        recv_q    <= recv_d;
        start_q   <= start_d;
        deliver_q <= deliver_d;
        discard_q <= discard_d;
        req_err_q <= req_err_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign mac_state_o      = state_q;
  assign radio_mode_o     = radio_q;
  assign start_send_o     = start_q;
  assign deliver_frame_o  = deliver_q;
  assign discard_frame_o  = discard_q;
  assign request_error_o  = req_err_q;
  assign sent_count_o     = sent_q;
  assign received_count_o = recv_q;

endmodule
